[sv/afnu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node update package
// Shared constants, step codes and control types of the travel-time node update.
// ----------------------------------------------------------------------------
package afnu_pkg;

    localparam int GRID_SIDE  = 16;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int CELL_BITS  = $clog2(GRID_CELLS);

    localparam logic [2:0] REG_SPEED    = 3'd0;
    localparam logic [2:0] REG_ANISO_X  = 3'd1;
    localparam logic [2:0] REG_ANISO_Y  = 3'd2;
    localparam logic [2:0] REG_ANISO_Z  = 3'd3;
    localparam logic [2:0] REG_MAX_TIME = 3'd4;

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [4:0] MS_PXX  = 5'd0;
    localparam logic [4:0] MS_PYY  = 5'd1;
    localparam logic [4:0] MS_PZZ  = 5'd2;
    localparam logic [4:0] MS_APX  = 5'd3;
    localparam logic [4:0] MS_APY  = 5'd4;
    localparam logic [4:0] MS_APZ  = 5'd5;
    localparam logic [4:0] MS_FF   = 5'd6;
    localparam logic [4:0] MS_AXX  = 5'd7;
    localparam logic [4:0] MS_AYY  = 5'd8;
    localparam logic [4:0] MS_AZZ  = 5'd9;
    localparam logic [4:0] MS_DD00 = 5'd10;
    localparam logic [4:0] MS_DD01 = 5'd11;
    localparam logic [4:0] MS_DD10 = 5'd12;
    localparam logic [4:0] MS_DD11 = 5'd13;
    localparam logic [4:0] MS_KX00 = 5'd14;
    localparam logic [4:0] MS_KX01 = 5'd15;
    localparam logic [4:0] MS_KX10 = 5'd16;
    localparam logic [4:0] MS_KX11 = 5'd17;

    localparam logic [5:0] MUL_STEPS  = 6'd18;
    localparam logic [5:0] SQRT_LAST  = 6'd48;
    localparam logic [5:0] DIV_LAST   = 6'd30;

    typedef struct packed {
        logic [30:0]        speed;
        logic signed [31:0] aniso_x;
        logic signed [31:0] aniso_y;
        logic signed [31:0] aniso_z;
        logic [30:0]        max_time;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       mem_rd;
        logic       mul_issue;
        logic [4:0] mul_step;
        logic       disc;
        logic       sqrt_step;
        logic       den;
        logic       div_step;
        logic       tsel;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic is_init;
        logic disc_pos;
        logic den_ok;
    } sts_t;

endpackage

[sv/afnu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node update controller
// Sequences read, products, square root, division and write-back of one item.
// ----------------------------------------------------------------------------
module afnu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_free,
    input  afnu_pkg::sts_t sts,
    output afnu_pkg::cmd_t cmd,
    output logic          in_stall
);
    import afnu_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_DISC = 8'b0000_1000,
        S_SQRT = 8'b0001_0000,
        S_DEN  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       tsel_reg, tsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            tsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tsel_reg  <= tsel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tsel_next  = 1'b0;
        cmd        = '0;
        cmd.mul_step = cnt_reg[4:0];
        cmd.tsel   = tsel_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                cnt_next   = '0;
                state_next = sts.is_init ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_issue = (cnt_reg < MUL_STEPS);
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == MUL_STEPS)
                begin
                    state_next = S_DISC;
                end
            end
            S_DISC:
            begin
                cmd.disc   = 1'b1;
                cnt_next   = '0;
                state_next = sts.disc_pos ? S_SQRT : S_DONE;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                cmd.den    = 1'b1;
                cnt_next   = '0;
                state_next = sts.den_ok ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    tsel_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free && !tsel_reg)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/afnu_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node update datapath
// Time grid memory, shared multiplier, square root and divider units.
// ----------------------------------------------------------------------------
module afnu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  afnu_pkg::cfg_t     cfg,
    input  afnu_pkg::cmd_t     cmd,
    input  logic               operation,
    input  logic [3:0]         node_x,
    input  logic [3:0]         node_y,
    input  logic [3:0]         node_z,
    input  logic               inside_flag,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output afnu_pkg::sts_t     sts,
    output logic signed [31:0] node_time_next,
    output logic               changed_next
);
    import afnu_pkg::*;

    logic [31:0]          mem [GRID_CELLS];
    logic [31:0]          rd_data_reg;
    logic [CELL_BITS-1:0] idx_reg;
    logic                 op_reg;
    logic                 inside_reg;
    logic signed [31:0]   px_reg, py_reg, pz_reg;

    logic signed [33:0]   mul_a, mul_b;
    logic signed [67:0]   prod_reg;
    logic [4:0]           pstep_reg;
    logic                 pvld_reg;

    logic [49:0]          xsq_reg;
    logic signed [49:0]   d_reg;
    logic signed [49:0]   k_reg;
    logic [99:0]          dd_reg;
    logic [99:0]          kx_reg;

    logic [99:0]          rem_reg, y_reg, bt_reg;
    logic [65:0]          num_reg;
    logic [80:0]          dsh_reg;
    logic [30:0]          q_reg;
    logic [30:0]          t_reg;

    logic                 neg;
    logic signed [33:0]   ax34, ay34, az34, asx, asy, asz;
    logic [49:0]          dm, km;
    logic signed [67:0]   f16, pneg, fn16;
    logic signed [100:0]  kxs, disc;
    logic [100:0]         trial;
    logic                 take;
    logic signed [50:0]   den;
    logic [81:0]          den31;
    logic                 ovf;
    logic [31:0]          mag, tval, newv, initv;
    logic                 upd;
    logic [CELL_BITS-1:0] idx_next;

    assign idx_next = CELL_BITS'((int'(node_x) % GRID_SIDE)
                    + GRID_SIDE * ((int'(node_y) % GRID_SIDE)
                    + GRID_SIDE * (int'(node_z) % GRID_SIDE)));

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mem[idx_reg] <= node_time_next;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= idx_next;
            op_reg     <= operation;
            inside_reg <= inside_flag;
            px_reg     <= point_x;
            py_reg     <= point_y;
            pz_reg     <= point_z;
        end
    end

    assign neg  = rd_data_reg[31];
    assign ax34 = 34'(cfg.aniso_x);
    assign ay34 = 34'(cfg.aniso_y);
    assign az34 = 34'(cfg.aniso_z);
    assign asx  = neg ? -ax34 : ax34;
    assign asy  = neg ? -ay34 : ay34;
    assign asz  = neg ? -az34 : az34;
    assign dm   = d_reg[49] ? 50'(-d_reg) : 50'(d_reg);
    assign km   = k_reg[49] ? 50'(-k_reg) : 50'(k_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_step) inside
            MS_PXX:  begin mul_a = 34'(px_reg); mul_b = 34'(px_reg); end
            MS_PYY:  begin mul_a = 34'(py_reg); mul_b = 34'(py_reg); end
            MS_PZZ:  begin mul_a = 34'(pz_reg); mul_b = 34'(pz_reg); end
            MS_APX:  begin mul_a = asx; mul_b = 34'(px_reg); end
            MS_APY:  begin mul_a = asy; mul_b = 34'(py_reg); end
            MS_APZ:  begin mul_a = asz; mul_b = 34'(pz_reg); end
            MS_FF:   begin mul_a = {3'b0, cfg.speed}; mul_b = {3'b0, cfg.speed}; end
            MS_AXX:  begin mul_a = ax34; mul_b = ax34; end
            MS_AYY:  begin mul_a = ay34; mul_b = ay34; end
            MS_AZZ:  begin mul_a = az34; mul_b = az34; end
            MS_DD00: begin mul_a = {9'b0, dm[24:0]};  mul_b = {9'b0, dm[24:0]}; end
            MS_DD01: begin mul_a = {9'b0, dm[24:0]};  mul_b = {9'b0, dm[49:25]}; end
            MS_DD10: begin mul_a = {9'b0, dm[49:25]}; mul_b = {9'b0, dm[24:0]}; end
            MS_DD11: begin mul_a = {9'b0, dm[49:25]}; mul_b = {9'b0, dm[49:25]}; end
            MS_KX00: begin mul_a = {9'b0, km[24:0]};  mul_b = {9'b0, xsq_reg[24:0]}; end
            MS_KX01: begin mul_a = {9'b0, km[24:0]};  mul_b = {9'b0, xsq_reg[49:25]}; end
            MS_KX10: begin mul_a = {9'b0, km[49:25]}; mul_b = {9'b0, xsq_reg[24:0]}; end
            MS_KX11: begin mul_a = {9'b0, km[49:25]}; mul_b = {9'b0, xsq_reg[49:25]}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign f16  = prod_reg >>> 16;
    assign pneg = -prod_reg;
    assign fn16 = pneg >>> 16;

    assign kxs  = k_reg[49] ? -$signed({1'b0, kx_reg}) : $signed({1'b0, kx_reg});
    assign disc = kxs + $signed({1'b0, dd_reg});

    assign trial = {1'b0, y_reg} + {1'b0, bt_reg};
    assign take  = (trial <= {1'b0, rem_reg});

    assign den   = $signed({d_reg[49], d_reg}) + $signed({2'b0, y_reg[48:0]});
    assign den31 = {1'b0, den[49:0], 31'b0};
    assign ovf   = ({16'b0, xsq_reg, 16'b0} >= den31);

    assign sts.is_init  = (op_reg == OP_INIT);
    assign sts.disc_pos = !disc[100] && (disc != '0);
    assign sts.den_ok   = !den[50] && (den != '0) && !ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= cmd.mul_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            prod_reg  <= mul_a * mul_b;
            pstep_reg <= cmd.mul_step;
        end
        if (cmd.load)
        begin
            xsq_reg <= '0;
            d_reg   <= '0;
            k_reg   <= '0;
            dd_reg  <= '0;
            kx_reg  <= '0;
        end
        else if (pvld_reg)
        begin
            case (pstep_reg) inside
                MS_PXX, MS_PYY, MS_PZZ: xsq_reg <= xsq_reg + f16[49:0];
                MS_APX, MS_APY, MS_APZ: d_reg <= d_reg + $signed(fn16[49:0]);
                MS_FF:                  k_reg <= k_reg + $signed(f16[49:0]);
                MS_AXX, MS_AYY, MS_AZZ: k_reg <= k_reg - $signed(f16[49:0]);
                MS_DD00:                dd_reg <= dd_reg + {50'b0, prod_reg[49:0]};
                MS_DD01, MS_DD10:       dd_reg <= dd_reg + {25'b0, prod_reg[49:0], 25'b0};
                MS_DD11:                dd_reg <= dd_reg + {prod_reg[49:0], 50'b0};
                MS_KX00:                kx_reg <= kx_reg + {50'b0, prod_reg[49:0]};
                MS_KX01, MS_KX10:       kx_reg <= kx_reg + {25'b0, prod_reg[49:0], 25'b0};
                MS_KX11:                kx_reg <= kx_reg + {prod_reg[49:0], 50'b0};
                default:                xsq_reg <= xsq_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.disc)
        begin
            rem_reg <= disc[99:0];
            y_reg   <= '0;
            bt_reg  <= 100'b1 << 96;
            t_reg   <= cfg.max_time;
        end
        else if (cmd.sqrt_step)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial[99:0];
                y_reg   <= (y_reg >> 1) + bt_reg;
            end
            else
            begin
                y_reg <= y_reg >> 1;
            end
            bt_reg <= bt_reg >> 2;
        end
        else if (cmd.tsel)
        begin
            t_reg <= (q_reg < cfg.max_time) ? q_reg : cfg.max_time;
        end
        if (cmd.den)
        begin
            num_reg <= {xsq_reg, 16'b0};
            dsh_reg <= {1'b0, den[49:0], 30'b0};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if ({15'b0, num_reg} >= dsh_reg)
            begin
                num_reg <= 66'({15'b0, num_reg} - dsh_reg);
                q_reg   <= {q_reg[29:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[29:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign initv = inside_reg ? -{1'b0, cfg.max_time} : {1'b0, cfg.max_time};
    assign mag   = neg ? -rd_data_reg : rd_data_reg;
    assign tval  = {1'b0, t_reg};
    assign upd   = (tval < mag);
    assign newv  = neg ? -tval : tval;

    always_comb
    begin
        if (op_reg == OP_INIT)
        begin
            node_time_next = initv;
            changed_next   = 1'b1;
        end
        else
        begin
            node_time_next = upd ? newv : rd_data_reg;
            changed_next   = upd;
        end
    end

endmodule

[sv/anisotropic_fold_time_node_update_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anisotropic travel-time node update core
// Initialise or update one signed Q16.16 node time per transfer.
// ----------------------------------------------------------------------------
// An update item runs 18 multiplier steps, then up to 49 square root steps and
// 31 divider steps; an initialise item skips all of them.
// Throughput: one item at a time; the next item is taken when the result is
// registered, while that result may still wait at the output.
// Reset clears control and sets configuration to defaults; grid entries stay undefined until written.
module anisotropic_fold_time_node_update_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [3:0]         node_x,
    input  logic [3:0]         node_y,
    input  logic [3:0]         node_z,
    input  logic               inside_flag,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] node_time,
    output logic               changed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import afnu_pkg::*;

    cfg_t               cfg_reg;
    cmd_t               cmd;
    sts_t               sts;
    logic               out_valid_reg;
    logic signed [31:0] node_time_reg;
    logic               changed_reg;
    logic signed [31:0] node_time_next;
    logic               changed_next;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign node_time = node_time_reg;
    assign changed   = changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed    <= 31'd65536;
            cfg_reg.aniso_x  <= '0;
            cfg_reg.aniso_y  <= '0;
            cfg_reg.aniso_z  <= '0;
            cfg_reg.max_time <= 31'h7FFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED:    cfg_reg.speed    <= cfg_data[30:0];
                REG_ANISO_X:  cfg_reg.aniso_x  <= cfg_data;
                REG_ANISO_Y:  cfg_reg.aniso_y  <= cfg_data;
                REG_ANISO_Z:  cfg_reg.aniso_z  <= cfg_data;
                REG_MAX_TIME: cfg_reg.max_time <= cfg_data[30:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            node_time_reg <= node_time_next;
            changed_reg   <= changed_next;
        end
    end

    afnu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    afnu_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .operation      (operation),
        .node_x         (node_x),
        .node_y         (node_y),
        .node_z         (node_z),
        .inside_flag    (inside_flag),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .sts            (sts),
        .node_time_next (node_time_next),
        .changed_next   (changed_next)
    );

endmodule
